FILE: design/aesp_pkg.sv
package aesp_pkg;

  localparam int DefMaxParams = 16;
  localparam int MaxResults = 16;
  localparam int QueueDepth = 4;
  localparam int ArgW = 21;
  localparam int ColW = 20;
  localparam int ValueLimit = 1000000;

  localparam logic [7:0] ChEsc = 8'h1B;
  localparam logic [7:0] ChDel = 8'h7F;
  localparam logic [7:0] ChBel = 8'h07;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChBs = 8'h08;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLbrack = 8'h5B;
  localparam logic [7:0] ChRbrack = 8'h5D;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChFinalLo = 8'h40;
  localparam logic [7:0] ChFinalHi = 8'h7E;

  localparam logic [4:0] CmdPrint = 5'd0;
  localparam logic [4:0] CmdBell = 5'd1;
  localparam logic [4:0] CmdCr = 5'd2;
  localparam logic [4:0] CmdLf = 5'd3;
  localparam logic [4:0] CmdBs = 5'd4;
  localparam logic [4:0] CmdTab = 5'd5;
  localparam logic [4:0] CmdUp = 5'd6;
  localparam logic [4:0] CmdDown = 5'd7;
  localparam logic [4:0] CmdFwd = 5'd8;
  localparam logic [4:0] CmdBack = 5'd9;
  localparam logic [4:0] CmdPos = 5'd10;
  localparam logic [4:0] CmdEraseDisp = 5'd11;
  localparam logic [4:0] CmdEraseLine = 5'd12;
  localparam logic [4:0] CmdSgrReset = 5'd13;
  localparam logic [4:0] CmdBold = 5'd14;
  localparam logic [4:0] CmdUnder = 5'd15;
  localparam logic [4:0] CmdInverse = 5'd16;
  localparam logic [4:0] CmdFg = 5'd17;
  localparam logic [4:0] CmdBg = 5'd18;

  typedef struct packed {
    logic [4:0] cmd;
    logic signed [ArgW-1:0] arg_a;
    logic [ColW-1:0] arg_b;
    logic last;
  } result_t;

  typedef struct packed {
    logic valid;
    logic [4:0] cmd;
    logic signed [ArgW-1:0] arg_a;
  } sgr_t;

  function automatic logic signed [ArgW-1:0] count_of(input logic signed [ArgW-1:0] v);
    count_of = (v <= 0) ? ArgW'(1) : v;
  endfunction

  function automatic sgr_t sgr_decode(input logic signed [ArgW-1:0] raw);
    logic signed [ArgW-1:0] p;
    sgr_t r;
    p = (raw < 0) ? '0 : raw;
    r.valid = 1'b1;
    r.cmd = CmdSgrReset;
    r.arg_a = '0;
    if (p == 0) begin
      r.cmd = CmdSgrReset;
    end else if (p == 1 || p == 22) begin
      r.cmd = CmdBold;
      r.arg_a = (p == 1) ? ArgW'(1) : '0;
    end else if (p == 4 || p == 24) begin
      r.cmd = CmdUnder;
      r.arg_a = (p == 4) ? ArgW'(1) : '0;
    end else if (p == 7 || p == 27) begin
      r.cmd = CmdInverse;
      r.arg_a = (p == 7) ? ArgW'(1) : '0;
    end else if (p >= 30 && p <= 37) begin
      r.cmd = CmdFg;
      r.arg_a = p - ArgW'(30);
    end else if (p == 39) begin
      r.cmd = CmdFg;
      r.arg_a = '1;
    end else if (p >= 90 && p <= 97) begin
      r.cmd = CmdFg;
      r.arg_a = p - ArgW'(82);
    end else if (p >= 40 && p <= 47) begin
      r.cmd = CmdBg;
      r.arg_a = p - ArgW'(40);
    end else if (p == 49) begin
      r.cmd = CmdBg;
      r.arg_a = '1;
    end else if (p >= 100 && p <= 107) begin
      r.cmd = CmdBg;
      r.arg_a = p - ArgW'(92);
    end else begin
      r.valid = 1'b0;
    end
    sgr_decode = r;
  endfunction

endpackage

FILE: design/aesp_front.sv
module aesp_front
  import aesp_pkg::*;
#(
  parameter int MAX_PARAMS = DefMaxParams
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic [7:0] byte_in,
  output logic ready,
  input  logic q_full,
  output logic out_valid,
  output result_t out_res
);

  localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int CW = $clog2(MAX_PARAMS + 1);

  localparam logic [2:0] ST_GROUND = 3'd0;
  localparam logic [2:0] ST_ESC = 3'd1;
  localparam logic [2:0] ST_CSI = 3'd2;
  localparam logic [2:0] ST_OSC = 3'd3;
  localparam logic [2:0] ST_WRD = 3'd4;
  localparam logic [2:0] ST_WPROC = 3'd5;
  localparam logic [2:0] ST_WEND = 3'd6;

  logic [2:0] state, state_next;
  logic [CW-1:0] count, count_next;
  logic signed [ArgW-1:0] cur, cur_next;
  logic has, has_next;
  logic saw, saw_next;
  logic signed [ArgW-1:0] p0, p0_next, p1, p1_next;
  logic [CW-1:0] idx, idx_next;
  logic [4:0] emitted, emitted_next;
  logic pend_valid, pend_valid_next;
  result_t pend, pend_next;

  logic signed [ArgW-1:0] store [MAX_PARAMS];
  logic signed [ArgW-1:0] rd_q;
  logic st_we;
  logic [IW-1:0] st_waddr;
  logic signed [ArgW-1:0] st_wdata;

  logic take;
  logic signed [ArgW-1:0] pv, get0, get1;
  logic pushing;
  logic [CW-1:0] eff_count;
  logic signed [ArgW-1:0] eff_p0, eff_p1;
  logic [24:0] acc;
  sgr_t dec;
  logic produce;

  assign ready = (state == ST_GROUND || state == ST_ESC || state == ST_CSI
                  || state == ST_OSC) && !q_full;
  assign take = push && ready;

  always_ff @(posedge clk) begin
    if (st_we) begin
      store[st_waddr] <= st_wdata;
    end
    rd_q <= store[idx[IW-1:0]];
  end

  always_comb begin
    pv = has ? cur : '1;
    // A final commits the value being built only if anything was typed.
    pushing = has || (count != '0);
    eff_count = (pushing && count < CW'(MAX_PARAMS)) ? count + CW'(1) : count;
    eff_p0 = (pushing && count == CW'(0)) ? pv : p0;
    eff_p1 = (pushing && count == CW'(1)) ? pv : p1;
    get0 = (eff_count > CW'(0)) ? eff_p0 : '1;
    get1 = (eff_count > CW'(1)) ? eff_p1 : '1;
    acc = {4'd0, cur} * 25'd10 + {17'd0, byte_in - ChZero};
    dec = sgr_decode(rd_q);
    produce = dec.valid && emitted < 5'(MaxResults);
  end

  always_comb begin
    state_next = state;
    count_next = count;
    cur_next = cur;
    has_next = has;
    saw_next = saw;
    p0_next = p0;
    p1_next = p1;
    idx_next = idx;
    emitted_next = emitted;
    pend_valid_next = pend_valid;
    pend_next = pend;
    st_we = 1'b0;
    st_waddr = count[IW-1:0];
    st_wdata = pv;
    out_valid = 1'b0;
    out_res = '{cmd: CmdPrint, arg_a: '0, arg_b: '0, last: 1'b1};

    case (state)
      ST_GROUND: begin
        if (take) begin
          out_valid = 1'b1;
          if (byte_in == ChEsc) begin
            out_valid = 1'b0;
            state_next = ST_ESC;
          end else if (byte_in == ChDel) begin
            out_valid = 1'b0;
          end else if (byte_in >= ChSpace) begin
            out_res.arg_a = ArgW'(byte_in);
          end else if (byte_in == ChBel) begin
            out_res.cmd = CmdBell;
          end else if (byte_in == ChCr) begin
            out_res.cmd = CmdCr;
          end else if (byte_in == ChLf) begin
            out_res.cmd = CmdLf;
          end else if (byte_in == ChBs) begin
            out_res.cmd = CmdBs;
          end else if (byte_in == ChTab) begin
            out_res.cmd = CmdTab;
          end else begin
            out_valid = 1'b0;
          end
        end
      end
      ST_ESC: begin
        if (take) begin
          if (byte_in == ChLbrack) begin
            count_next = '0;
            cur_next = '1;
            has_next = 1'b0;
            state_next = ST_CSI;
          end else if (byte_in == ChRbrack) begin
            saw_next = 1'b0;
            state_next = ST_OSC;
          end else begin
            state_next = ST_GROUND;
          end
        end
      end
      ST_CSI: begin
        if (take) begin
          if (byte_in >= ChZero && byte_in <= ChNine) begin
            if (!has || cur < 0) begin
              cur_next = ArgW'(byte_in - ChZero);
            end else if (acc > 25'(ValueLimit)) begin
              cur_next = ArgW'(ValueLimit);
            end else begin
              cur_next = acc[ArgW-1:0];
            end
            has_next = 1'b1;
          end else if (byte_in == ChSemi) begin
            if (count < CW'(MAX_PARAMS)) begin
              st_we = 1'b1;
              count_next = count + CW'(1);
              if (count == CW'(0)) p0_next = pv;
              if (count == CW'(1)) p1_next = pv;
            end
            cur_next = '1;
            has_next = 1'b0;
          end else if (byte_in >= ChFinalLo && byte_in <= ChFinalHi) begin
            st_we = pushing && count < CW'(MAX_PARAMS);
            cur_next = '1;
            has_next = 1'b0;
            count_next = '0;
            state_next = ST_GROUND;
            out_valid = 1'b1;
            case (byte_in)
              "A": begin
                out_res.cmd = CmdUp;
                out_res.arg_a = count_of(get0);
              end
              "B": begin
                out_res.cmd = CmdDown;
                out_res.arg_a = count_of(get0);
              end
              "C": begin
                out_res.cmd = CmdFwd;
                out_res.arg_a = count_of(get0);
              end
              "D": begin
                out_res.cmd = CmdBack;
                out_res.arg_a = count_of(get0);
              end
              "H", "f": begin
                out_res.cmd = CmdPos;
                out_res.arg_a = count_of(get0);
                out_res.arg_b = ColW'(count_of(get1));
              end
              "J": begin
                out_res.cmd = CmdEraseDisp;
                out_res.arg_a = (get0 < 0) ? '0 : get0;
              end
              "K": begin
                out_res.cmd = CmdEraseLine;
                out_res.arg_a = (get0 < 0) ? '0 : get0;
              end
              "m": begin
                if (eff_count == CW'(0)) begin
                  out_res.cmd = CmdSgrReset;
                end else begin
                  // Hand the stored list to the walk, one entry at a time.
                  out_valid = 1'b0;
                  count_next = eff_count;
                  idx_next = '0;
                  emitted_next = '0;
                  pend_valid_next = 1'b0;
                  state_next = ST_WRD;
                end
              end
              default: out_valid = 1'b0;
            endcase
          end
        end
      end
      ST_OSC: begin
        if (take) begin
          if (saw && byte_in == ChBslash) begin
            saw_next = 1'b0;
            state_next = ST_GROUND;
          end else if (byte_in == ChBel) begin
            saw_next = 1'b0;
            state_next = ST_GROUND;
          end else begin
            saw_next = (byte_in == ChEsc);
          end
        end
      end
      ST_WRD: begin
        state_next = ST_WPROC;
      end
      ST_WPROC: begin
        if (!(produce && pend_valid && q_full)) begin
          if (produce) begin
            out_valid = pend_valid;
            out_res = pend;
            out_res.last = 1'b0;
            pend_valid_next = 1'b1;
            pend_next = '{cmd: dec.cmd, arg_a: dec.arg_a, arg_b: '0, last: 1'b1};
            emitted_next = emitted + 5'd1;
          end
          if (idx == count - CW'(1)) begin
            state_next = ST_WEND;
          end else begin
            idx_next = idx + CW'(1);
            state_next = ST_WRD;
          end
        end
      end
      ST_WEND: begin
        if (!pend_valid) begin
          count_next = '0;
          state_next = ST_GROUND;
        end else if (!q_full) begin
          out_valid = 1'b1;
          out_res = pend;
          out_res.last = 1'b1;
          pend_valid_next = 1'b0;
          count_next = '0;
          state_next = ST_GROUND;
        end
      end
      default: state_next = ST_GROUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_GROUND;
      count <= '0;
      cur <= '1;
      has <= 1'b0;
      saw <= 1'b0;
      idx <= '0;
      emitted <= '0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      cur <= cur_next;
      has <= has_next;
      saw <= saw_next;
      idx <= idx_next;
      emitted <= emitted_next;
      pend_valid <= pend_valid_next;
    end
    p0 <= p0_next;
    p1 <= p1_next;
    pend <= pend_next;
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !q_full) else $error("result pushed into a full queue");
  a_emit_limit: assert property (@(posedge clk) disable iff (rst)
    emitted <= 5'(MaxResults)) else $error("too many results for one byte");
  a_no_take_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRD || state == ST_WPROC || state == ST_WEND) |-> !ready)
    else $error("byte taken during parameter walk");
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WPROC) |-> (idx < count)) else $error("walk index past count");

endmodule

FILE: design/aesp_queue.sv
module aesp_queue
  import aesp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  result_t wr_data,
  output logic q_full,
  input  logic pop,
  output logic empty,
  output result_t rd_data
);

  localparam int PW = $clog2(QueueDepth);

  result_t slots [QueueDepth];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0] fill;
  logic do_pop;

  assign q_full = (fill == (PW+1)'(QueueDepth));
  assign empty = (fill == '0);
  assign do_pop = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + PW'(1);
      if (do_pop) rd_ptr <= rd_ptr + PW'(1);
      fill <= fill + (PW+1)'(wr_en) - (PW+1)'(do_pop);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (PW+1)'(QueueDepth)) else $error("queue fill out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full && !do_pop |-> !wr_en) else $error("queue overflow");
  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !do_pop) |=> fill == $past(fill) + (PW+1)'(1))
    else $error("fill count did not advance");

endmodule

FILE: design/ansi_escape_sequence_parser_core.sv
// A result is written into the result queue in the same cycle that its byte is taken;
// SGR results follow as the walk reaches them, the last one written when the walk ends.
// Throughput: one byte per cycle while the queue is not full, except an SGR final,
// which walks its stored parameters one at a time through the single store read port.
// A four-entry result queue separates the parser from the consumer.
// Synchronous reset returns the parser to ground and empties the queue; the
// parameter store is not cleared and is only read below the stored count.
module ansi_escape_sequence_parser_core
  import aesp_pkg::*;
#(
  parameter int MAX_PARAMS = DefMaxParams
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [7:0] byte_in,
  output logic empty,
  input  logic pop,
  output logic [4:0] command,
  output logic signed [20:0] first_arg,
  output logic [19:0] second_arg,
  output logic last_of_run
);

  logic ready, q_full, f_valid;
  result_t f_res, q_res;

  aesp_front #(.MAX_PARAMS(MAX_PARAMS)) u_front (
    .clk(clk), .rst(rst), .push(push), .byte_in(byte_in), .ready(ready),
    .q_full(q_full), .out_valid(f_valid), .out_res(f_res)
  );

  aesp_queue u_queue (
    .clk(clk), .rst(rst), .wr_en(f_valid), .wr_data(f_res), .q_full(q_full),
    .pop(pop), .empty(empty), .rd_data(q_res)
  );

  assign full = !ready;
  assign command = q_res.cmd;
  assign first_arg = q_res.arg_a;
  assign second_arg = q_res.arg_b;
  assign last_of_run = q_res.last;

endmodule

FILE: tb/testbench.sv
module testbench;
  import aesp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumParams = DefMaxParams;

  typedef enum logic [1:0] {
    ModeGround = 2'd0,
    ModeEscape = 2'd1,
    ModeCsi = 2'd2,
    ModeOsc = 2'd3
  } parse_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic [7:0] byte_in = '0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  logic [4:0] command;
  logic signed [20:0] first_arg;
  logic [19:0] second_arg;
  logic last_of_run;

  ansi_escape_sequence_parser_core #(.MAX_PARAMS(NumParams)) u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .byte_in(byte_in),
    .empty(empty),
    .pop(pop),
    .command(command),
    .first_arg(first_arg),
    .second_arg(second_arg),
    .last_of_run(last_of_run)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow parser state.
  parse_mode_e mode_q;
  int param_vals[NumParams];
  int param_cnt;
  int cur_val;
  bit cur_has_digits;
  bit osc_esc;
  int run_len;

  result_t expected_cmds[$];
  int mismatches = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  int hold_off_cycles = 0;

  task automatic add_cmd(input logic [4:0] c, input int a, input int b);
    result_t r;
    if (run_len >= MaxResults) begin
      return;
    end
    r.cmd = c;
    r.arg_a = a[ArgW-1:0];
    r.arg_b = b[ColW-1:0];
    r.last = 1'b0;
    expected_cmds.insert(expected_cmds.size(), r);
    run_len++;
  endtask

  function automatic int clamp_count(input int v);
    return (v <= 0) ? 1 : v;
  endfunction

  function automatic int param_at(input int i);
    return (i >= param_cnt) ? -1 : param_vals[i];
  endfunction

  task automatic store_value();
    if (param_cnt < NumParams) begin
      param_vals[param_cnt] = cur_has_digits ? cur_val : -1;
      param_cnt++;
    end
  endtask

  task automatic reset_params();
    param_cnt = 0;
    cur_val = -1;
    cur_has_digits = 1'b0;
  endtask

  task automatic add_sgr(input int raw);
    int p;
    p = (raw < 0) ? 0 : raw;
    if (p == 0) add_cmd(CmdSgrReset, 0, 0);
    else if (p == 1) add_cmd(CmdBold, 1, 0);
    else if (p == 22) add_cmd(CmdBold, 0, 0);
    else if (p == 4) add_cmd(CmdUnder, 1, 0);
    else if (p == 24) add_cmd(CmdUnder, 0, 0);
    else if (p == 7) add_cmd(CmdInverse, 1, 0);
    else if (p == 27) add_cmd(CmdInverse, 0, 0);
    else if (p >= 30 && p <= 37) add_cmd(CmdFg, p - 30, 0);
    else if (p == 39) add_cmd(CmdFg, -1, 0);
    else if (p >= 90 && p <= 97) add_cmd(CmdFg, 8 + p - 90, 0);
    else if (p >= 40 && p <= 47) add_cmd(CmdBg, p - 40, 0);
    else if (p == 49) add_cmd(CmdBg, -1, 0);
    else if (p >= 100 && p <= 107) add_cmd(CmdBg, 8 + p - 100, 0);
  endtask

  task automatic finish_csi(input logic [7:0] c);
    int v;
    if (cur_has_digits || param_cnt > 0) store_value();
    case (c)
      "A": add_cmd(CmdUp, clamp_count(param_at(0)), 0);
      "B": add_cmd(CmdDown, clamp_count(param_at(0)), 0);
      "C": add_cmd(CmdFwd, clamp_count(param_at(0)), 0);
      "D": add_cmd(CmdBack, clamp_count(param_at(0)), 0);
      "H", "f": add_cmd(CmdPos, clamp_count(param_at(0)), clamp_count(param_at(1)));
      "J": begin
        v = param_at(0);
        add_cmd(CmdEraseDisp, (v < 0) ? 0 : v, 0);
      end
      "K": begin
        v = param_at(0);
        add_cmd(CmdEraseLine, (v < 0) ? 0 : v, 0);
      end
      "m": begin
        if (param_cnt == 0) begin
          add_cmd(CmdSgrReset, 0, 0);
        end else begin
          for (int i = 0; i < param_cnt; i++) add_sgr(param_vals[i]);
        end
      end
      default: ;
    endcase
    reset_params();
  endtask

  task automatic predict_byte(input logic [7:0] c);
    int t;
    run_len = 0;
    case (mode_q)
      ModeGround: begin
        if (c == ChEsc) mode_q = ModeEscape;
        else if (c == ChDel) ;
        else if (c >= ChSpace) add_cmd(CmdPrint, int'(c), 0);
        else if (c == ChBel) add_cmd(CmdBell, 0, 0);
        else if (c == ChCr) add_cmd(CmdCr, 0, 0);
        else if (c == ChLf) add_cmd(CmdLf, 0, 0);
        else if (c == ChBs) add_cmd(CmdBs, 0, 0);
        else if (c == ChTab) add_cmd(CmdTab, 0, 0);
      end
      ModeEscape: begin
        if (c == ChLbrack) begin
          reset_params();
          mode_q = ModeCsi;
        end else if (c == ChRbrack) begin
          osc_esc = 1'b0;
          mode_q = ModeOsc;
        end else begin
          mode_q = ModeGround;
        end
      end
      ModeCsi: begin
        if (c >= ChZero && c <= ChNine) begin
          if (!cur_has_digits || cur_val < 0) begin
            cur_val = int'(c - ChZero);
          end else begin
            t = cur_val * 10 + int'(c - ChZero);
            cur_val = (t > ValueLimit) ? ValueLimit : t;
          end
          cur_has_digits = 1'b1;
        end else if (c == ChSemi) begin
          store_value();
          cur_val = -1;
          cur_has_digits = 1'b0;
        end else if (c >= ChFinalLo && c <= ChFinalHi) begin
          finish_csi(c);
          mode_q = ModeGround;
        end
      end
      default: begin
        if (osc_esc && c == ChBslash) begin
          osc_esc = 1'b0;
          mode_q = ModeGround;
        end else begin
          osc_esc = 1'b0;
          if (c == ChBel) mode_q = ModeGround;
          else if (c == ChEsc) osc_esc = 1'b1;
        end
      end
    endcase
    if (run_len > 0) expected_cmds[$].last = 1'b1;
  endtask

  // Push stays high between back-to-back beats; it drops only while idling.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    byte_in <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    push <= 1'b0;
    while (expected_cmds.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  // Consumer: pop with random stall bursts; a long hold-off overrides.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        pop <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 13) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Checker: compares every beat taken from the result queue.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && pop && !empty) begin
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected beat: cmd=%0d a=%0d b=%0d last=%0b",
                   command, first_arg, second_arg, last_of_run);
        end
      end else begin
        exp_r = expected_cmds.pop_front();
        if (exp_r.cmd !== command || exp_r.arg_a !== first_arg ||
            exp_r.arg_b !== second_arg || exp_r.last !== last_of_run) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("beat mismatch: expected cmd=%0d a=%0d b=%0d last=%0b,",
                     exp_r.cmd, exp_r.arg_a, exp_r.arg_b, exp_r.last,
                     " got cmd=%0d a=%0d b=%0d last=%0b",
                     command, first_arg, second_arg, last_of_run);
          end
        end
      end
    end
  end

  task automatic test_ground_bytes();
    send_byte(8'h00);
    send_byte(ChBel);
    send_byte(ChCr);
    send_byte(ChLf);
    send_byte(ChBs);
    send_byte(ChTab);
    send_byte(8'h1F);
    send_byte(ChDel);
    send_byte(ChSpace);
    send_byte(8'h7E);
    send_byte(8'h80);
    send_byte(8'hFF);
  endtask

  task automatic test_csi_commands();
    send_text("\033[A\033[0B\033[5C\033[12D\033[;H\033[3;7f");
    send_text("\033[J\033[2K\033[m\033[1;22;4;24;7;27;31;39;95;42;49;107;0;;5m");
    send_text("\033[99999999A\033[1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;17;18H");
    send_text("\033[1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;17m");
    send_text("\033[5 \177\001\377q\033[5m\033[7x\033(B\033]title\033\\\033]x\007");
    send_text("\033]\033a\033\033\\");
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 300;
    for (int i = 0; i < 30; i++) send_byte(8'h41 + i[7:0]);
    wait_drained();
  endtask

  function automatic logic [7:0] pick_sgr_byte();
    case ($urandom_range(0, 5))
      0: return ChSemi;
      1: return "1";
      2: return "3";
      3: return "4";
      4: return "9";
      default: return ChZero + 8'($urandom_range(0, 9));
    endcase
  endfunction

  task automatic test_random_stream(input int n_items, input bit gaps);
    int sent;
    int len;
    logic [7:0] finals[10];
    finals = '{"A", "B", "C", "D", "H", "f", "J", "K", "m", "z"};
    send_gaps = gaps;
    recv_gaps = gaps;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          send_byte(8'($urandom_range(0, 255)));
          sent++;
        end
        2, 3, 4, 5: begin
          send_byte(ChEsc);
          send_byte(ChLbrack);
          len = $urandom_range(0, 20);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) send_byte(8'($urandom_range(0, 255)));
            else send_byte(pick_sgr_byte());
          end
          send_byte(finals[$urandom_range(0, 9)]);
          sent += len + 3;
        end
        6: begin
          send_byte(ChEsc);
          send_byte(ChRbrack);
          len = $urandom_range(0, 6);
          for (int i = 0; i < len; i++) send_byte(8'($urandom_range(32, 126)));
          if ($urandom_range(0, 1)) begin
            send_byte(ChBel);
          end else begin
            send_byte(ChEsc);
            send_byte(ChBslash);
          end
          sent += len + 4;
        end
        default: begin
          send_byte(8'($urandom_range(32, 126)));
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    mode_q = ModeGround;
    osc_esc = 1'b0;
    reset_params();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_ground_bytes();
    test_csi_commands();
    test_backpressure();
    test_random_stream(40, 1'b1);
    test_random_stream(20, 1'b0);
    wait_drained();
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
